// File: rtl/srle_pkg.sv
// ----------------------------------------------------------------------------
// srle_pkg
// shared types and constants for the sun raster run-length pixel decoder
// ----------------------------------------------------------------------------
package srle_pkg;

  localparam int MAX_DIMENSION_DEF = 8192;

  // configuration port
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_MODE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RGB_ORDER     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RUN_LENGTH_ON = 3'd4;

  // depth modes
  localparam logic [1:0] DEPTH_1BIT  = 2'd0;
  localparam logic [1:0] DEPTH_8BIT  = 2'd1;
  localparam logic [1:0] DEPTH_24BIT = 2'd2;
  localparam logic [1:0] DEPTH_32BIT = 2'd3;

  // input operations
  localparam logic OP_RAW_BYTE = 1'b0;
  localparam logic OP_CONTINUE = 1'b1;

  localparam logic [7:0] ESCAPE_BYTE = 8'h80;
  localparam int         POS_W       = 13;

  // decoded byte handed from the escape decoder to the pixel assembler
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       pending;
  } dec_byte_t;

  typedef struct packed {
    logic [1:0] depth_mode;
    logic       rgb_order;
  } pix_cfg_t;

  typedef struct packed {
    logic [7:0]       pixel_bits;
    logic [3:0]       pixel_count;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [POS_W-1:0] row_number;
    logic [POS_W-1:0] column_number;
    logic             last_pixel;
    logic             run_pending;
  } result_t;

endpackage

// File: rtl/srle_escape.sv
// ----------------------------------------------------------------------------
// srle_escape
// undoes the 0x80 escape run-length code and releases run copies
// ----------------------------------------------------------------------------
module srle_escape (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                operation,
  input  logic [7:0]          raw_byte,
  input  logic                run_length_on,
  output srle_pkg::dec_byte_t dec
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ESC   = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] value_r, value_nxt;
  logic       out_valid;
  logic [7:0] out_data;

  always_comb begin
    phase_nxt  = phase_r;
    remain_nxt = remain_r;
    value_nxt  = value_r;
    out_valid  = 1'b0;
    out_data   = raw_byte;
    if (fire) begin
      if (operation == srle_pkg::OP_CONTINUE) begin
        if (remain_r != 8'd0) begin
          remain_nxt = remain_r - 8'd1;
          out_valid  = 1'b1;
          out_data   = value_r;
        end
      end else if (remain_r == 8'd0) begin
        if (!run_length_on) begin
          phase_nxt = PH_IDLE;
          out_valid = 1'b1;
        end else begin
          case (phase_r)
            PH_ESC: begin
              if (raw_byte == 8'd0) begin
                phase_nxt = PH_IDLE;
                out_valid = 1'b1;
                out_data  = srle_pkg::ESCAPE_BYTE;
              end else begin
                remain_nxt = raw_byte;
                phase_nxt  = PH_COUNT;
              end
            end
            PH_COUNT: begin
              value_nxt = raw_byte;
              phase_nxt = PH_IDLE;
              out_valid = 1'b1;
            end
            default: begin
              if (raw_byte == srle_pkg::ESCAPE_BYTE) begin
                phase_nxt = PH_ESC;
              end else begin
                phase_nxt = PH_IDLE;
                out_valid = 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      remain_r <= 8'd0;
      value_r  <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      value_r  <= value_nxt;
    end
  end

  assign dec.valid   = out_valid;
  assign dec.data    = out_data;
  assign dec.pending = (remain_nxt != 8'd0);

endmodule

// File: rtl/srle_pixel.sv
// ----------------------------------------------------------------------------
// srle_pixel
// assembles decoded bytes into pixels and tracks row, column and row padding
// ----------------------------------------------------------------------------
module srle_pixel #(
  parameter int MAX_DIMENSION = srle_pkg::MAX_DIMENSION_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             restart,
  input  logic [$clog2(MAX_DIMENSION):0]   image_width,
  input  logic [$clog2(MAX_DIMENSION):0]   image_height,
  input  srle_pkg::pix_cfg_t               cfg,
  input  srle_pkg::dec_byte_t              dec,
  output logic                             res_valid,
  output srle_pkg::result_t                res
);

  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam int DIM_W = CNT_W + 1;

  logic [1:0]       bip_r, bip_nxt;
  logic [15:0]      hold_r, hold_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic             pad_r, pad_nxt;

  logic             emit;
  logic [3:0]       n_pix;
  logic [7:0]       bits;
  logic [7:0]       red, blue;
  logic [DIM_W-1:0] span_left;
  logic [DIM_W-1:0] col_sum;
  logic [DIM_W:0]   width_plus7;
  logic             row_pad;
  logic             last;
  logic [1:0]       first;

  assign span_left   = image_width - DIM_W'(col_r);
  assign col_sum     = DIM_W'(col_r) + DIM_W'(n_pix);
  assign width_plus7 = (DIM_W+1)'(image_width) + (DIM_W+1)'(7);
  assign first       = (cfg.depth_mode == srle_pkg::DEPTH_32BIT) ? 2'd1 : 2'd0;

  always_comb begin
    case (cfg.depth_mode)
      srle_pkg::DEPTH_1BIT:  row_pad = width_plus7[3];
      srle_pkg::DEPTH_32BIT: row_pad = 1'b0;
      default:               row_pad = image_width[0];
    endcase
  end

  // byte assembly
  always_comb begin
    bip_nxt  = bip_r;
    hold_nxt = hold_r;
    pad_nxt  = pad_r;
    emit     = 1'b0;
    n_pix    = 4'd1;
    bits     = 8'd0;
    red      = 8'd0;
    blue     = 8'd0;
    if (dec.valid) begin
      if (pad_r) begin
        pad_nxt = 1'b0;
      end else begin
        case (cfg.depth_mode)
          srle_pkg::DEPTH_1BIT: begin
            n_pix = (span_left > DIM_W'(8)) ? 4'd8 : span_left[3:0];
            bits  = dec.data & ~(8'hFF >> n_pix);
            emit  = 1'b1;
          end
          srle_pkg::DEPTH_8BIT: begin
            bits = dec.data;
            emit = 1'b1;
          end
          default: begin
            if (cfg.depth_mode == srle_pkg::DEPTH_32BIT && bip_r == 2'd0) begin
              // leading pad byte of a 32-bit pixel
              bip_nxt = 2'd1;
            end else if (bip_r == first) begin
              hold_nxt = {hold_r[15:8], dec.data};
              bip_nxt  = bip_r + 2'd1;
            end else if (bip_r == first + 2'd1) begin
              hold_nxt = {dec.data, hold_r[7:0]};
              bip_nxt  = bip_r + 2'd1;
            end else begin
              bip_nxt = 2'd0;
              emit    = 1'b1;
              red     = cfg.rgb_order ? hold_r[7:0] : dec.data;
              blue    = cfg.rgb_order ? dec.data : hold_r[7:0];
            end
          end
        endcase
      end
    end
  end

  // position tracking
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    last    = 1'b0;
    if (emit) begin
      if (col_sum >= image_width) begin
        last    = (DIM_W'(row_r) + DIM_W'(1) >= image_height);
        col_nxt = '0;
        row_nxt = last ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_sum[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bip_r  <= 2'd0;
      hold_r <= 16'd0;
      col_r  <= '0;
      row_r  <= '0;
      pad_r  <= 1'b0;
    end else if (restart) begin
      bip_r  <= 2'd0;
      hold_r <= 16'd0;
      col_r  <= '0;
      row_r  <= '0;
      pad_r  <= 1'b0;
    end else begin
      bip_r  <= bip_nxt;
      hold_r <= hold_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pad_r  <= (emit && col_sum >= image_width) ? row_pad : pad_nxt;
    end
  end

  assign res_valid         = emit;
  assign res.pixel_bits    = bits;
  assign res.pixel_count   = n_pix;
  assign res.red           = red;
  assign res.green         = (cfg.depth_mode == srle_pkg::DEPTH_24BIT ||
                              cfg.depth_mode == srle_pkg::DEPTH_32BIT) ? hold_r[15:8] : 8'd0;
  assign res.blue          = blue;
  assign res.row_number    = srle_pkg::POS_W'(row_r);
  assign res.column_number = srle_pkg::POS_W'(col_r);
  assign res.last_pixel    = last;
  assign res.run_pending   = dec.pending;

endmodule

// File: rtl/sun_raster_rle_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// sun_raster_rle_pixel_decoder_unit
// decodes escape run-length coded raster body bytes into pixels
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    in_operation, in_raw_byte
//  out      source     out_valid / out_stall  pixel, colour, position, flags
//  cfg      sink       cfg_write_en           cfg_index, cfg_data
//
//  one item per cycle while out_stall is low; an item passes the input register,
//  then decode and assembly into the result register
//  rst_n is synchronous; it clears decode state and loads register defaults
//  out_stall holds the result register and the input register behind it;
//  in_stall rises only while the input register is full and cannot move
//  a register write restarts the image at row 0, column 0
module sun_raster_rle_pixel_decoder_unit #(
  parameter int MAX_DIMENSION = srle_pkg::MAX_DIMENSION_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_write_en,
  input  logic [srle_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srle_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [7:0]                       in_raw_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_pixel_bits,
  output logic [3:0]                       out_pixel_count,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic [12:0]                      out_row_number,
  output logic [12:0]                      out_column_number,
  output logic                             out_last_pixel,
  output logic                             out_run_pending
);

  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam int DIM_W = CNT_W + 1;
  localparam int CMP_W = (srle_pkg::CFG_DATA_W > 17) ? srle_pkg::CFG_DATA_W : 17;

  // configuration registers
  logic [DIM_W-1:0]   width_r, height_r;
  logic [1:0]         depth_r;
  logic               rgb_r;
  logic               rle_r;
  logic [DIM_W-1:0]   cfg_dim;
  logic               restart;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_dim = DIM_W'(1);
    end else if (CMP_W'(cfg_data) > CMP_W'(MAX_DIMENSION)) begin
      cfg_dim = DIM_W'(MAX_DIMENSION);
    end else begin
      cfg_dim = DIM_W'(cfg_data);
    end
  end

  always_comb begin
    case (cfg_index)
      srle_pkg::REG_IMAGE_WIDTH,
      srle_pkg::REG_IMAGE_HEIGHT,
      srle_pkg::REG_DEPTH_MODE,
      srle_pkg::REG_RGB_ORDER,
      srle_pkg::REG_RUN_LENGTH_ON: restart = cfg_write_en;
      default:                     restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      depth_r  <= srle_pkg::DEPTH_8BIT;
      rgb_r    <= 1'b0;
      rle_r    <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        srle_pkg::REG_IMAGE_WIDTH:   width_r  <= cfg_dim;
        srle_pkg::REG_IMAGE_HEIGHT:  height_r <= cfg_dim;
        srle_pkg::REG_DEPTH_MODE:    depth_r  <= cfg_data[1:0];
        srle_pkg::REG_RGB_ORDER:     rgb_r    <= cfg_data[0];
        srle_pkg::REG_RUN_LENGTH_ON: rle_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid_r;
  logic       s1_op_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic       advance;
  logic       fire;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r   <= in_operation;
      s1_byte_r <= in_raw_byte;
    end
  end

  // decode and assembly
  srle_pkg::dec_byte_t dec;
  srle_pkg::pix_cfg_t  pix_cfg;
  srle_pkg::result_t   res;
  logic                res_valid;

  assign pix_cfg.depth_mode = depth_r;
  assign pix_cfg.rgb_order  = rgb_r;

  srle_escape u_escape (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .operation     (s1_op_r),
    .raw_byte      (s1_byte_r),
    .run_length_on (rle_r),
    .dec           (dec)
  );

  srle_pixel #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_pixel (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (restart),
    .image_width  (width_r),
    .image_height (height_r),
    .cfg          (pix_cfg),
    .dec          (dec),
    .res_valid    (res_valid),
    .res          (res)
  );

  // result register
  srle_pkg::result_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_bits    = out_r.pixel_bits;
  assign out_pixel_count   = out_r.pixel_count;
  assign out_red           = out_r.red;
  assign out_green         = out_r.green;
  assign out_blue          = out_r.blue;
  assign out_row_number    = out_r.row_number;
  assign out_column_number = out_r.column_number;
  assign out_last_pixel    = out_r.last_pixel;
  assign out_run_pending   = out_r.run_pending;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_count != 4'd0 && out_pixel_count <= 4'd8))
    else $error("pixel count out of range");

  a_single_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && depth_r != srle_pkg::DEPTH_1BIT) |-> out_pixel_count == 4'd1)
    else $error("multi-pixel result outside 1-bit mode");

  a_colour_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (depth_r == srle_pkg::DEPTH_24BIT || depth_r == srle_pkg::DEPTH_32BIT))
      |-> out_pixel_bits == 8'd0)
    else $error("index bits set in colour mode");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room to move");

endmodule
